FILE: hw/rtl/pwbd_pkg.sv
// Shared types, register indexes and color helper functions for the pixel write back end.
// No dependencies; imported by pwbd_color, pixel_write_blend_dither and the bench tb_top.
package pwbd_pkg;

    localparam int ADDR_W = 19;

    // Interlaced field selections; any other code draws every line.
    localparam logic [1:0] FIELD_EVEN = 2'd1;
    localparam logic [1:0] FIELD_ODD  = 2'd2;

    typedef enum logic [1:0] {
        BLEND_AVG = 2'd0,
        BLEND_ADD = 2'd1,
        BLEND_SUB = 2'd2,
        BLEND_QTR = 2'd3
    } blend_mode_t;

    typedef enum logic [2:0] {
        REG_FIELD_MODE  = 3'd0,
        REG_DRAW_LEFT   = 3'd1,
        REG_DRAW_RIGHT  = 3'd2,
        REG_DRAW_TOP    = 3'd3,
        REG_DRAW_BOTTOM = 3'd4,
        REG_CHECK_MASK  = 3'd5,
        REG_FORCE_MASK  = 3'd6,
        REG_BLEND_MODE  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        semi;
        logic        dither;
        blend_mode_t mode;
    } color_ctrl_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // Ordered 4x4 dither bias, indexed by {row[1:0], column[1:0]}.
    function automatic logic signed [3:0] dither_bias(input logic [3:0] idx);
        logic signed [3:0] b;
        case (idx)
            4'd0:    b = -4'sd4;
            4'd1:    b = 4'sd0;
            4'd2:    b = -4'sd3;
            4'd3:    b = 4'sd1;
            4'd4:    b = 4'sd2;
            4'd5:    b = -4'sd2;
            4'd6:    b = 4'sd3;
            4'd7:    b = -4'sd1;
            4'd8:    b = -4'sd3;
            4'd9:    b = 4'sd1;
            4'd10:   b = -4'sd4;
            4'd11:   b = 4'sd0;
            4'd12:   b = 4'sd3;
            4'd13:   b = -4'sd1;
            4'd14:   b = 4'sd2;
            4'd15:   b = -4'sd2;
            default: b = 4'sd0;
        endcase
        return b;
    endfunction

    // Expand a channel to 8 bits, add the bias, clamp to 0..255 and narrow back.
    function automatic logic [4:0] dither_ch(input logic [4:0] v, input logic signed [3:0] b);
        logic signed [9:0] t;
        t = $signed({2'b00, expand5(v)}) + $signed({{6{b[3]}}, b});
        if (t[9])
            return 5'd0;
        else if (t[8])
            return 5'd31;
        else
            return t[7:3];
    endfunction

endpackage

FILE: hw/rtl/pixel_write_blend_dither.sv
// Top level of the pixel write back end: clip, field and mask tests, address and final word.
// Depends on pwbd_pkg and instantiates pwbd_color for the dither and blend stages.
//
// Channel   Ports                                              Direction
// request   start, busy (out), pos_x, pos_y, pixel_color,      in
//           semi_transparent, dither_enable, dest_pixel
// result    result_valid, write_enable, write_address,         out
//           write_value
// config    psel, penable, pwrite, paddr, pwdata, prdata,      in / out
//           pready
//
// A request is taken every cycle; busy is tied low. Each request gives one result,
// strobed by result_valid for one cycle, after passing the three register stages:
// dither and tests, blend and address add, final word. The receiver cannot stall,
// so the pipeline always advances. Reset clears the valid bits and loads the register
// defaults; it is asynchronous and active low.
module pixel_write_blend_dither
    import pwbd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 512
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [11:0]       pos_x,
    input  logic signed [11:0]       pos_y,
    input  logic [15:0]              pixel_color,
    input  logic                     semi_transparent,
    input  logic                     dither_enable,
    input  logic [15:0]              dest_pixel,
    output logic                     result_valid,
    output logic                     write_enable,
    output logic [ADDR_W-1:0]        write_address,
    output logic [15:0]              write_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam logic [11:0] SCR_W = 12'(SCREEN_WIDTH);
    localparam logic [11:0] SCR_H = 12'(SCREEN_HEIGHT);

    // Configuration registers
    logic [1:0]  field_mode_reg;
    logic [9:0]  draw_left_reg;
    logic [9:0]  draw_right_reg;
    logic [8:0]  draw_top_reg;
    logic [8:0]  draw_bottom_reg;
    logic        check_mask_reg;
    logic        force_mask_reg;
    blend_mode_t blend_mode_reg;

    logic        cfg_write;
    reg_index_t  cfg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_mode_reg  <= 2'd0;
            draw_left_reg   <= 10'd0;
            draw_right_reg  <= 10'd1023;
            draw_top_reg    <= 9'd0;
            draw_bottom_reg <= 9'd511;
            check_mask_reg  <= 1'b0;
            force_mask_reg  <= 1'b0;
            blend_mode_reg  <= BLEND_AVG;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FIELD_MODE:  field_mode_reg  <= pwdata[1:0];
                REG_DRAW_LEFT:   draw_left_reg   <= pwdata[9:0];
                REG_DRAW_RIGHT:  draw_right_reg  <= pwdata[9:0];
                REG_DRAW_TOP:    draw_top_reg    <= pwdata[8:0];
                REG_DRAW_BOTTOM: draw_bottom_reg <= pwdata[8:0];
                REG_CHECK_MASK:  check_mask_reg  <= pwdata[0];
                REG_FORCE_MASK:  force_mask_reg  <= pwdata[0];
                REG_BLEND_MODE:  blend_mode_reg  <= blend_mode_t'(pwdata[1:0]);
                default:         field_mode_reg  <= field_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FIELD_MODE:  prdata = {30'd0, field_mode_reg};
            REG_DRAW_LEFT:   prdata = {22'd0, draw_left_reg};
            REG_DRAW_RIGHT:  prdata = {22'd0, draw_right_reg};
            REG_DRAW_TOP:    prdata = {23'd0, draw_top_reg};
            REG_DRAW_BOTTOM: prdata = {23'd0, draw_bottom_reg};
            REG_CHECK_MASK:  prdata = {31'd0, check_mask_reg};
            REG_FORCE_MASK:  prdata = {31'd0, force_mask_reg};
            REG_BLEND_MODE:  prdata = {30'd0, blend_mode_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Stage 1: write tests and the row part of the address.
    logic              accept;
    logic [11:0]       x_u;
    logic [11:0]       y_u;
    logic              x_in;
    logic              y_in;
    logic              field_ok;
    logic              s1_ok_next;
    logic [19:0]       row_prod;
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic [ADDR_W-1:0] s1_prod_reg;
    logic [9:0]        s1_x_reg;
    color_ctrl_t       color_ctrl;
    logic [15:0]       color_word;

    assign accept = start & ~busy;

    always_comb
    begin
        x_u = pos_x;
        y_u = pos_y;
        // A negative coordinate has its top bit set and so fails the screen bound.
        x_in = (x_u >= {2'b00, draw_left_reg}) && (x_u <= {2'b00, draw_right_reg})
               && (x_u < SCR_W);
        y_in = (y_u >= {3'b000, draw_top_reg}) && (y_u <= {3'b000, draw_bottom_reg})
               && (y_u < SCR_H);
        if (field_mode_reg == FIELD_EVEN)
            field_ok = ~pos_y[0];
        else if (field_mode_reg == FIELD_ODD)
            field_ok = pos_y[0];
        else
            field_ok = 1'b1;
        s1_ok_next = x_in & y_in & field_ok & ~(check_mask_reg & dest_pixel[15]);
        row_prod   = {11'd0, y_u[8:0]} * {8'd0, SCR_W};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg   <= s1_ok_next;
        s1_prod_reg <= row_prod[ADDR_W-1:0];
        s1_x_reg    <= x_u[9:0];
    end

    assign color_ctrl = '{semi: semi_transparent, dither: dither_enable, mode: blend_mode_reg};

    pwbd_color u_color
    (
        .clk         (clk),
        .ctrl        (color_ctrl),
        .dither_idx  ({pos_y[1:0], pos_x[1:0]}),
        .pixel_color (pixel_color),
        .dest_pixel  (dest_pixel),
        .color_out   (color_word)
    );

    // Stage 2: finish the address; the color path blends alongside.
    logic              s2_valid_reg;
    logic              s2_ok_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [ADDR_W-1:0] s2_addr_next;

    assign s2_addr_next = s1_prod_reg + {{(ADDR_W-10){1'b0}}, s1_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_ok_reg   <= s1_ok_reg;
        s2_addr_reg <= s2_addr_next;
    end

    // Stage 3: a skipped write shows zero address and value.
    logic              out_valid_reg;
    logic              out_we_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [ADDR_W-1:0] out_addr_next;
    logic [15:0]       out_value_reg;
    logic [15:0]       out_value_next;

    always_comb
    begin
        if (s2_ok_reg)
        begin
            out_addr_next  = s2_addr_reg;
            out_value_next = {color_word[15] | force_mask_reg, color_word[14:0]};
        end
        else
        begin
            out_addr_next  = '0;
            out_value_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_we_reg    <= s2_ok_reg;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
    end

    assign result_valid  = out_valid_reg;
    assign write_enable  = out_we_reg;
    assign write_address = out_addr_reg;
    assign write_value   = out_value_reg;

endmodule

FILE: hw/rtl/pwbd_color.sv
// Two-stage color path: ordered dither, then semi-transparent blend with the destination.
// Depends on pwbd_pkg for the control struct, dither table and channel helpers.
module pwbd_color
    import pwbd_pkg::*;
(
    input  logic        clk,
    input  color_ctrl_t ctrl,
    input  logic [3:0]  dither_idx,
    input  logic [15:0] pixel_color,
    input  logic [15:0] dest_pixel,
    output logic [15:0] color_out
);

    logic [14:0]       a_color_reg, a_color_next;
    logic              a_mask_reg, a_mask_next;
    logic [14:0]       a_dest_reg;
    logic              a_semi_reg;
    blend_mode_t       a_mode_reg;
    logic [15:0]       b_color_reg, b_color_next;
    logic signed [3:0] bias;

    // Stage A: dither. The source mask bit survives only when the color is untouched.
    always_comb
    begin
        bias = dither_bias(dither_idx);
        if (ctrl.dither)
        begin
            a_color_next = {dither_ch(pixel_color[14:10], bias),
                            dither_ch(pixel_color[9:5], bias),
                            dither_ch(pixel_color[4:0], bias)};
        end
        else
        begin
            a_color_next = pixel_color[14:0];
        end
        a_mask_next = pixel_color[15] & ~ctrl.dither & ~ctrl.semi;
    end

    always_ff @(posedge clk)
    begin
        a_color_reg <= a_color_next;
        a_mask_reg  <= a_mask_next;
        a_dest_reg  <= dest_pixel[14:0];
        a_semi_reg  <= ctrl.semi;
        a_mode_reg  <= ctrl.mode;
    end

    function automatic logic [4:0] blend_ch(input blend_mode_t mode, input logic [4:0] src,
                                            input logic [4:0] dst);
        logic [7:0] s;
        logic [7:0] d;
        logic [8:0] sum;
        logic [8:0] diff;
        logic [8:0] qsum;
        logic [7:0] r;
        s    = expand5(src);
        d    = expand5(dst);
        sum  = {1'b0, s} + {1'b0, d};
        diff = {1'b0, d} - {1'b0, s};
        qsum = {1'b0, d} + {3'b000, s[7:2]};
        case (mode)
            BLEND_AVG: r = sum[8:1];
            BLEND_ADD: r = sum[8] ? 8'hFF : sum[7:0];
            BLEND_SUB: r = diff[8] ? 8'h00 : diff[7:0];
            BLEND_QTR: r = qsum[8] ? 8'hFF : qsum[7:0];
            default:   r = sum[8:1];
        endcase
        return r[7:3];
    endfunction

    // Stage B: when semi-transparent, blend each channel with the destination word; else pass color and mask on.
    always_comb
    begin
        if (a_semi_reg)
        begin
            b_color_next = {1'b0,
                            blend_ch(a_mode_reg, a_color_reg[14:10], a_dest_reg[14:10]),
                            blend_ch(a_mode_reg, a_color_reg[9:5], a_dest_reg[9:5]),
                            blend_ch(a_mode_reg, a_color_reg[4:0], a_dest_reg[4:0])};
        end
        else
        begin
            b_color_next = {a_mask_reg, a_color_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        b_color_reg <= b_color_next;
    end

    assign color_out = b_color_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for pixel_write_blend_dither: pixel requests, APB register writes and
// a predictor of the write decision, address and blended word, checked against each result.
// Depends on pwbd_pkg and the pixel_write_blend_dither RTL.
module tb_top
    import pwbd_pkg::*;
();

    localparam int SCR_W = 1024;
    localparam int SCR_H = 512;
    localparam logic [1:0] FIELD_ALL   = 2'd0;
    localparam logic [1:0] FIELD_SPARE = 2'd3;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 80;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] color;
        logic        semi;
        logic        dith;
        logic [15:0] dest;
    } pixel_req_t;

    typedef struct packed {
        logic        we;
        logic [18:0] addr;
        logic [15:0] val;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [11:0] pos_x = '0;
    logic signed [11:0] pos_y = '0;
    logic [15:0] pixel_color = '0;
    logic semi_transparent = 1'b0;
    logic dither_enable = 1'b0;
    logic [15:0] dest_pixel = '0;
    logic result_valid;
    logic write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [15:0] write_value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Register copies, loaded with the reset values.
    logic [1:0]  cfg_field = FIELD_ALL;
    logic [9:0]  cfg_left = 10'd0;
    logic [9:0]  cfg_right = 10'd1023;
    logic [8:0]  cfg_top = 9'd0;
    logic [8:0]  cfg_bottom = 9'd511;
    logic        cfg_check = 1'b0;
    logic        cfg_force = 1'b0;
    blend_mode_t cfg_blend = BLEND_AVG;

    pixel_req_t   pend_q [$];
    pixel_write_t writes_q [$];
    int  fail_count = 0;
    int  gap_left = 0;
    logic burst = 1'b0;

    pixel_write_blend_dither u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pixel_color      (pixel_color),
        .semi_transparent (semi_transparent),
        .dither_enable    (dither_enable),
        .dest_pixel       (dest_pixel),
        .result_valid     (result_valid),
        .write_enable     (write_enable),
        .write_address    (write_address),
        .write_value      (write_value),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int dither_at(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd10: return -4;
            4'd2, 4'd8:  return -3;
            4'd5, 4'd15: return -2;
            4'd7, 4'd13: return -1;
            4'd1, 4'd11: return 0;
            4'd3, 4'd9:  return 1;
            4'd4, 4'd14: return 2;
            default:     return 3;
        endcase
    endfunction

    function automatic int widen(input logic [15:0] word, input int shift);
        int v;
        v = (word >> shift) & 31;
        return (v << 3) | (v >> 2);
    endfunction

    function automatic logic [4:0] narrow(input int v);
        int c;
        c = (v < 0) ? 0 : ((v > 255) ? 255 : v);
        return c[7:3];
    endfunction

    function automatic int mix(input int s, input int d);
        int r;
        case (cfg_blend)
            BLEND_AVG: r = (s + d) / 2;
            BLEND_ADD: r = (s + d > 255) ? 255 : s + d;
            BLEND_SUB: r = (d - s < 0) ? 0 : d - s;
            default:   r = (d + s / 4 > 255) ? 255 : d + s / 4;
        endcase
        return r;
    endfunction

    function automatic pixel_write_t predict_write(input pixel_req_t r);
        pixel_write_t res;
        int x, y, bias;
        logic ok;
        logic [15:0] word;
        res = '0;
        x = {{20{r.x[11]}}, r.x};
        y = {{20{r.y[11]}}, r.y};
        ok = 1'b1;
        if ((cfg_field == FIELD_EVEN && r.y[0]) || (cfg_field == FIELD_ODD && !r.y[0]))
            ok = 1'b0;
        if (x < int'(cfg_left) || x > int'(cfg_right) || y < int'(cfg_top) ||
            y > int'(cfg_bottom) || x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            ok = 1'b0;
        if (ok && cfg_check && r.dest[15])
            ok = 1'b0;
        if (ok)
        begin
            word = r.color;
            if (r.dith)
            begin
                bias = dither_at({r.y[1:0], r.x[1:0]});
                word = {1'b0, narrow(widen(word, 10) + bias), narrow(widen(word, 5) + bias),
                        narrow(widen(word, 0) + bias)};
            end
            if (r.semi)
                word = {1'b0, narrow(mix(widen(word, 10), widen(r.dest, 10))),
                        narrow(mix(widen(word, 5), widen(r.dest, 5))),
                        narrow(mix(widen(word, 0), widen(r.dest, 0)))};
            if (cfg_force)
                word[15] = 1'b1;
            res.we = 1'b1;
            res.addr = 19'(y * SCR_W + x);
            res.val = word;
        end
        return res;
    endfunction

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Request driver: records each accepted request and presents the next one after its gap.
    always @(posedge clk)
    begin : request_driver
        pixel_req_t acc;
        pixel_req_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                acc = {pos_x, pos_y, pixel_color, semi_transparent, dither_enable, dest_pixel};
                writes_q.push_back(predict_write(acc));
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pend_q.size() > 0)
            begin
                nxt = pend_q.pop_front();
                pos_x <= nxt.x;
                pos_y <= nxt.y;
                pixel_color <= nxt.color;
                semi_transparent <= nxt.semi;
                dither_enable <= nxt.dith;
                dest_pixel <= nxt.dest;
                start <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 14);
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        pixel_write_t got;
        pixel_write_t want;
        if (rst_n && result_valid)
        begin
            got = {write_enable, write_address, write_value};
            if (writes_q.size() == 0)
                note_fail($sformatf("unexpected result we=%0d addr=%05h val=%04h",
                                    got.we, got.addr, got.val));
            else
            begin
                want = writes_q.pop_front();
                if (got.we !== want.we || got.addr !== want.addr || got.val !== want.val)
                    note_fail($sformatf("mismatch: exp we=%0d addr=%05h val=%04h, got we=%0d addr=%05h val=%04h",
                                        want.we, want.addr, want.val, got.we, got.addr, got.val));
            end
        end
    end

    task automatic push_req(input int x, input int y, input logic [15:0] color,
                            input logic semi, input logic dith, input logic [15:0] dest);
        pixel_req_t r;
        r.x = x[11:0];
        r.y = y[11:0];
        r.color = color;
        r.semi = semi;
        r.dith = dith;
        r.dest = dest;
        pend_q.push_back(r);
    endtask

    task automatic push_random(input int n);
        pixel_req_t r;
        int i;
        int pick;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7 && cfg_left <= cfg_right)
                r.x = 12'($urandom_range(cfg_left, cfg_right));
            else if (pick < 9)
                r.x = 12'($urandom_range(0, SCR_W - 1));
            else
                r.x = 12'($urandom());
            pick = $urandom_range(0, 9);
            if (pick < 7 && cfg_top <= cfg_bottom)
                r.y = 12'($urandom_range(cfg_top, cfg_bottom));
            else if (pick < 9)
                r.y = 12'($urandom_range(0, SCR_H - 1));
            else
                r.y = 12'($urandom());
            // In an interlaced field most rows match the drawn parity.
            if ((cfg_field == FIELD_EVEN || cfg_field == FIELD_ODD) && $urandom_range(0, 4) != 0)
                r.y[0] = (cfg_field == FIELD_ODD);
            r.color = 16'($urandom());
            r.semi = 1'($urandom_range(0, 1));
            r.dith = 1'($urandom_range(0, 1));
            r.dest = 16'($urandom());
            pend_q.push_back(r);
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FIELD_MODE:  cfg_field = data[1:0];
            REG_DRAW_LEFT:   cfg_left = data[9:0];
            REG_DRAW_RIGHT:  cfg_right = data[9:0];
            REG_DRAW_TOP:    cfg_top = data[8:0];
            REG_DRAW_BOTTOM: cfg_bottom = data[8:0];
            REG_CHECK_MASK:  cfg_check = data[0];
            REG_FORCE_MASK:  cfg_force = data[0];
            default:         cfg_blend = blend_mode_t'(data[1:0]);
        endcase
    endtask

    // Waits until every request has gone through, then rewrites all registers.
    // The check is made at the falling edge, after the driver's updates have settled.
    task automatic set_config(input logic [1:0] fm, input int left, input int right,
                              input int top, input int bottom, input logic chk,
                              input logic frc, input blend_mode_t bm);
        do
            @(negedge clk);
        while (pend_q.size() != 0 || start || writes_q.size() != 0);
        write_reg(REG_FIELD_MODE, 32'(fm));
        write_reg(REG_DRAW_LEFT, 32'(left));
        write_reg(REG_DRAW_RIGHT, 32'(right));
        write_reg(REG_DRAW_TOP, 32'(top));
        write_reg(REG_DRAW_BOTTOM, 32'(bottom));
        write_reg(REG_CHECK_MASK, 32'(chk));
        write_reg(REG_FORCE_MASK, 32'(frc));
        write_reg(REG_BLEND_MODE, 32'(bm));
    endtask

    task automatic random_config(input int phase);
        int kind, a, b, c, d, t;
        case (phase)
            0: set_config(FIELD_ALL, 0, 1023, 0, 511, 1'b0, 1'b0, BLEND_AVG);
            1: set_config(FIELD_ODD, 1023, 1023, 511, 511, 1'b1, 1'b1, BLEND_QTR);
            2: set_config(FIELD_ALL, 0, 0, 0, 0, 1'b0, 1'b0, BLEND_AVG);
            default:
            begin
                kind = $urandom_range(0, 3);
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
                c = $urandom_range(0, 511);
                d = $urandom_range(0, 511);
                case (kind)
                    0:
                    begin
                        a = 0; b = 1023; c = 0; d = 511;
                    end
                    1:
                    begin
                        if (a > b)
                        begin
                            t = a; a = b; b = t;
                        end
                        if (c > d)
                        begin
                            t = c; c = d; d = t;
                        end
                    end
                    2: ; // both pairs of bounds unordered, so the rectangle may be empty
                    default:
                    begin
                        b = (a + $urandom_range(0, 7) > 1023) ? 1023 : a + $urandom_range(0, 7);
                        d = (c + $urandom_range(0, 7) > 511) ? 511 : c + $urandom_range(0, 7);
                    end
                endcase
                set_config(2'($urandom_range(0, 3)), a, b, c, d, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), blend_mode_t'($urandom_range(0, 3)));
            end
        endcase
    endtask

    initial
    begin : stimulus
        int ph;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: mask bit pass-through, dither clamping, screen edges.
        push_req(0, 0, 16'hFFFF, 1'b0, 1'b0, 16'h0000);
        push_req(1023, 511, 16'h7FFF, 1'b0, 1'b1, 16'h0000);
        push_req(0, 0, 16'h0000, 1'b0, 1'b1, 16'hFFFF);
        push_req(-2048, -2048, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        push_req(2047, 2047, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        push_req(1024, 0, 16'h1234, 1'b0, 1'b0, 16'h0000);
        push_req(0, 512, 16'h1234, 1'b0, 1'b0, 16'h0000);
        push_req(-1, 5, 16'h1234, 1'b0, 1'b0, 16'h0000);
        push_req(3, 2, 16'h7FFF, 1'b1, 1'b0, 16'h8000);

        // Saturating add, mask test and forced mask.
        set_config(FIELD_ALL, 0, 1023, 0, 511, 1'b1, 1'b1, BLEND_ADD);
        push_req(10, 10, 16'h7FFF, 1'b1, 1'b0, 16'h7FFF);
        push_req(11, 10, 16'h1234, 1'b0, 1'b0, 16'h8000);
        push_req(12, 13, 16'h4210, 1'b1, 1'b1, 16'h0421);

        // Floored subtract on even lines only.
        set_config(FIELD_EVEN, 0, 1023, 0, 511, 1'b0, 1'b0, BLEND_SUB);
        push_req(20, 40, 16'h7FFF, 1'b1, 1'b0, 16'h0000);
        push_req(20, 41, 16'h7FFF, 1'b1, 1'b0, 16'h0000);
        push_req(21, 42, 16'h0421, 1'b1, 1'b1, 16'h7FFF);

        // Quarter add on odd lines only.
        set_config(FIELD_ODD, 0, 1023, 0, 511, 1'b0, 1'b0, BLEND_QTR);
        push_req(30, 31, 16'h7FFF, 1'b1, 1'b0, 16'h7FFF);
        push_req(30, 32, 16'h7FFF, 1'b1, 1'b0, 16'h7FFF);

        // Field code three draws every line; an empty rectangle draws nothing.
        set_config(FIELD_SPARE, 600, 599, 300, 200, 1'b0, 1'b0, BLEND_AVG);
        push_req(600, 100, 16'h5555, 1'b0, 1'b0, 16'h0000);
        push_req(599, 250, 16'h5555, 1'b0, 1'b0, 16'h0000);

        // Single-pixel rectangle.
        set_config(FIELD_SPARE, 5, 5, 7, 7, 1'b0, 1'b0, BLEND_AVG);
        push_req(5, 7, 16'h2AAA, 1'b0, 1'b0, 16'h0000);
        push_req(6, 7, 16'h2AAA, 1'b0, 1'b0, 16'h0000);
        push_req(5, 8, 16'h2AAA, 1'b0, 1'b0, 16'h0000);
        push_req(4, 7, 16'h2AAA, 1'b0, 1'b0, 16'h0000);

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            random_config(ph);
            push_random(PHASE_ITEMS);
        end

        while (pend_q.size() != 0 || start)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (writes_q.size() != 0)
            note_fail($sformatf("%0d results never arrived", writes_q.size()));
        if (fail_count == 0)
            $display("** pixel_write_blend_dither: PASSED **");
        else
            $display("** pixel_write_blend_dither: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("** pixel_write_blend_dither: FAILED **");
        $finish;
    end

endmodule
